### design/pst_pkg.sv
// Shared constants and status types for the prime and square test block.
package pst_pkg;

  // Default operand width and the width of the input value port
  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned IN_VALUE_W      = 32;

  // First trial divisor
  localparam int unsigned FIRST_DIVISOR   = 2;

  // Status of the square root unit
  typedef struct packed {
    logic done;   // one-cycle pulse: root is final
    logic exact;  // remainder is zero, value is a perfect square
  } sqrt_stat_t;

  // Status of the remainder unit
  typedef struct packed {
    logic done;   // one-cycle pulse: remainder is final
    logic zero;   // remainder is zero, divisor divides the value
  } div_stat_t;

endpackage

### design/prime_and_square_test_core.sv
// Top level: square root, then trial division sequenced over a shared remainder unit.
//
//   channel  | ports                              | handshake
//   ---------+------------------------------------+-------------------------------
//   input    | in_value[31:0]                     | accepted when start && !busy
//   result   | out_is_square, out_is_prime        | out_valid strobe, one cycle
//
// Sequence: the root is found first, then each trial divisor
// d = 2 .. floor(sqrt(value)) is tried in turn in the remainder unit,
// stopping at the first divisor found.
// The result strobe is registered in the cycle after the last unit finishes; busy is low then.
// Reset is synchronous, active low, and clears the sequencer and unit control.
// The receiver cannot stall: each result is shown for exactly one cycle.
module prime_and_square_test_core
  import pst_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_VALUE_W-1:0] in_value,
  output logic                  out_valid,
  output logic                  out_is_square,
  output logic                  out_is_prime
);

  localparam int unsigned DW = (VALUE_WIDTH + 1) / 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_TRY
  } state_t;

  state_t                 state_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [DW-1:0]          d_r;
  logic                   sq_r;
  logic                   div_go_r;
  logic                   out_valid_r;
  logic                   out_is_square_r;
  logic                   out_is_prime_r;

  logic [VALUE_WIDTH+IN_VALUE_W-1:0] in_ext;
  logic [VALUE_WIDTH-1:0]            in_val;
  logic                              accept;
  logic [DW-1:0]                     root;
  sqrt_stat_t                        sqrt_st;
  div_stat_t                         div_st;
  logic                              val_small;
  logic                              root_small;

  // Keep the low VALUE_WIDTH bits of the item
  assign in_ext = {{VALUE_WIDTH{1'b0}}, in_value};
  assign in_val = in_ext[VALUE_WIDTH-1:0];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Values below two are never prime; a root below two leaves no divisor to try
  assign val_small  = ((val_r >> 1) == '0);
  assign root_small = ((root >> 1) == '0);

  pst_sqrt #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (accept),
    .operand(in_val),
    .root   (root),
    .stat   (sqrt_st)
  );

  pst_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (div_go_r),
    .dividend(val_r),
    .divisor (d_r),
    .stat    (div_st)
  );

  // Sequence root, then one trial divisor after another
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            val_r   <= in_val;
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_st.done) begin
            sq_r <= sqrt_st.exact;
            if (val_small || root_small) begin
              out_valid_r     <= 1'b1;
              out_is_square_r <= sqrt_st.exact;
              out_is_prime_r  <= !val_small;
              state_r         <= ST_IDLE;
            end else begin
              d_r      <= DW'(FIRST_DIVISOR);
              div_go_r <= 1'b1;
              state_r  <= ST_TRY;
            end
          end
        end
        ST_TRY: begin
          if (div_st.done) begin
            if (div_st.zero || (d_r == root)) begin
              out_valid_r     <= 1'b1;
              out_is_square_r <= sq_r;
              out_is_prime_r  <= !div_st.zero;
              state_r         <= ST_IDLE;
            end else begin
              d_r      <= d_r + DW'(1);
              div_go_r <= 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_square = out_is_square_r;
  assign out_is_prime  = out_is_prime_r;

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after accepting an item");

  // A prime is never a perfect square
  a_prime_not_square: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_square && out_is_prime))
    else $error("result reports a prime perfect square");

  // A result only follows work in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // The remainder unit is launched only while trying divisors
  a_div_in_try: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> (state_r == ST_TRY))
    else $error("divider launched outside trial division");

endmodule

### design/pst_sqrt.sv
// Digit-by-digit integer square root, two operand bits per cycle.
module pst_sqrt
  import pst_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [VALUE_WIDTH-1:0]         operand,
  output logic [(VALUE_WIDTH+1)/2-1:0]   root,
  output sqrt_stat_t                     stat
);

  localparam int unsigned EW = VALUE_WIDTH + (VALUE_WIDTH % 2);
  localparam int unsigned RW = EW / 2;
  localparam int unsigned CW = $clog2(RW + 1);

  logic [EW-1:0] opnd_r;
  logic [RW-1:0] root_r;
  logic [RW+1:0] rem_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;

  logic [RW+2:0] rem_sh;
  logic [RW+2:0] trial;
  logic          ge;
  logic [RW+2:0] rem_sub;

  // Bring down the next digit pair and try the candidate bit
  assign rem_sh  = {rem_r[RW:0], opnd_r[EW-1 -: 2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = ge ? (rem_sh - trial) : rem_sh;

  // Iterate one root bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        opnd_r <= EW'(operand);
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= CW'(RW);
        run_r  <= 1'b1;
      end else if (run_r) begin
        opnd_r <= {opnd_r[EW-3:0], 2'b00};
        root_r <= {root_r[RW-2:0], ge};
        rem_r  <= rem_sub[RW+1:0];
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root       = root_r;
  assign stat.done  = done_r;
  assign stat.exact = (rem_r == '0);

endmodule

### design/pst_div.sv
// Restoring shift-subtract remainder unit, one dividend bit per cycle.
module pst_div
  import pst_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [VALUE_WIDTH-1:0]         dividend,
  input  logic [(VALUE_WIDTH+1)/2-1:0]   divisor,
  output div_stat_t                      stat
);

  localparam int unsigned DW = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] quo_r;
  logic [DW-1:0]          dvs_r;
  logic [DW-1:0]          rem_r;
  logic [CW-1:0]          cnt_r;
  logic                   run_r;
  logic                   done_r;

  logic [DW:0] rem_sh;
  logic        ge;
  logic [DW:0] rem_sub;

  // Shift in the next dividend bit and subtract where it fits
  assign rem_sh  = {rem_r, quo_r[VALUE_WIDTH-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        quo_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        cnt_r <= CW'(VALUE_WIDTH);
        run_r <= 1'b1;
      end else if (run_r) begin
        quo_r <= {quo_r[VALUE_WIDTH-2:0], 1'b0};
        rem_r <= rem_sub[DW-1:0];
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule
